/* rtl/core/assert_macros.svh */
// Assertion macros used by the port-level checker of this block (stl_checker).
// No dependencies; pull in with `include inside a module body or file head.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/stl_pkg.sv */
// Stereo tremolo package: item types, register indexes, sine table builder.
// No dependencies.
`default_nettype none

package stl_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SINE_BITS   = 16;
    localparam int PHASE_BITS  = 32;
    localparam int CFG_BITS    = 32;
    localparam int DEPTH_BITS  = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = 16'h8000;

    localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH        = 2'd2;

    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET   = 32'd581610;
    localparam logic [PHASE_BITS-1:0] PHASE_OFFSET_RESET = 32'h8000_0000;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
        logic                          block_end;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          block_last;
    } out_t;

    // Item handed from front to back: LFO phases for both channels plus samples.
    typedef struct packed {
        logic [PHASE_BITS-1:0] phase_l;
        logic [PHASE_BITS-1:0] phase_r;
        in_t                   sample;
    } mid_t;

    // sin(2*pi*idx/2^bits) in Q1.15, quarter-wave Taylor series in Q30.
    // Used only at elaboration to fill the sine ROM.
    function automatic logic signed [SINE_BITS-1:0] sine_entry(
        input int unsigned idx,
        input int unsigned bits
    );
        longint unsigned quarter;
        longint unsigned r;
        longint unsigned t;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned u;
        longint unsigned q15;
        longint unsigned quad;
        logic signed [SINE_BITS-1:0] mag;
        quarter = 64'd1 << (bits - 2);
        quad    = (longint'(idx) >> (bits - 2)) & 64'd3;
        r       = longint'(idx) & (quarter - 64'd1);
        if (quad[0])
            r = quarter - r;
        t  = r << (32 - bits);
        x  = (t * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        u  = Q30_ONE;
        u  = Q30_ONE - ((x2 * u) >> 30) / 110;
        u  = Q30_ONE - ((x2 * u) >> 30) / 72;
        u  = Q30_ONE - ((x2 * u) >> 30) / 42;
        u  = Q30_ONE - ((x2 * u) >> 30) / 20;
        u  = Q30_ONE - ((x2 * u) >> 30) / 6;
        q15 = (((x * u) >> 30) + 64'd16384) >> 15;
        if (q15 > 64'd32767)
            q15 = 64'd32767;
        mag = SINE_BITS'(q15);
        if (quad[1])
            return -mag;
        return mag;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/stl_fifo.sv */
// Small register queue with full/empty flags, used between front and back
// and on the result side. Depends on nothing; item type is a parameter.
`default_nettype none

module stl_fifo #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 2
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        wr_en,
    input  wire item_t wr_item,
    output logic       full,
    input  wire        rd_en,
    output item_t      rd_item,
    output logic       empty
);
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

    item_t               mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_wr;
    logic                do_rd;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_BITS'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_BITS'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_BITS'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_item;
    end

endmodule

`default_nettype wire

/* rtl/core/stl_front.sv */
// Front end: config registers, phase accumulator, item intake.
// Depends on stl_pkg.
`default_nettype none

module stl_front (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  push,
    output logic                                 full,
    input  wire  stl_pkg::in_t                   sample,
    input  wire                                  cfg_we,
    input  wire  [stl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire  [stl_pkg::CFG_BITS-1:0]         cfg_data,
    input  wire                                  mid_full,
    output logic                                 mid_push,
    output stl_pkg::mid_t                        mid_item,
    output logic [stl_pkg::DEPTH_BITS-1:0]       depth
);
    import stl_pkg::*;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] offset_reg;
    logic [DEPTH_BITS-1:0] depth_reg;

    assign full     = mid_full;
    assign mid_push = push && !mid_full;

    assign mid_item.phase_l = phase_reg;
    assign mid_item.phase_r = phase_reg + offset_reg;
    assign mid_item.sample  = sample;

    assign phase_next = phase_reg + step_reg;

    // depth above full acts as full
    assign depth = (depth_reg > DEPTH_FULL) ? DEPTH_FULL : depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            step_reg   <= PHASE_STEP_RESET;
            offset_reg <= PHASE_OFFSET_RESET;
            depth_reg  <= '0;
        end
        else
        begin
            if (mid_push)
                phase_reg <= phase_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PHASE_STEP:   step_reg   <= cfg_data;
                    REG_PHASE_OFFSET: offset_reg <= cfg_data;
                    REG_DEPTH:        depth_reg  <= cfg_data[DEPTH_BITS-1:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/stl_back.sv */
// Back end: sine ROM lookup, gain, scaling, rounding and saturation.
// Depends on stl_pkg (types, sine_entry).
`default_nettype none

module stl_back #(
    parameter int SINE_INDEX_BITS = 10
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  mid_empty,
    input  wire  stl_pkg::mid_t                  mid_head,
    output logic                                 mid_pop,
    input  wire  [stl_pkg::DEPTH_BITS-1:0]       depth,
    input  wire                                  out_full,
    output logic                                 out_push,
    output stl_pkg::out_t                        out_item
);
    import stl_pkg::*;

    localparam int TABLE_SIZE = 1 << SINE_INDEX_BITS;
    localparam int GAIN_BITS  = 32;
    localparam int PROD_BITS  = SAMPLE_BITS + GAIN_BITS;
    localparam int Y_BITS     = PROD_BITS - 30;
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(64'd1 << 29);
    localparam logic signed [Y_BITS-1:0] Y_MAX = Y_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Y_BITS-1:0] Y_MIN = -Y_MAX - Y_BITS'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GAIN,
        S_MUL,
        S_PUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [SINE_BITS-1:0] sine_rom [TABLE_SIZE];

    logic signed [SINE_BITS-1:0]   sin_l_reg;
    logic signed [SINE_BITS-1:0]   sin_r_reg;
    logic signed [SAMPLE_BITS-1:0] x_l_reg;
    logic signed [SAMPLE_BITS-1:0] x_r_reg;
    logic                          last_reg;
    logic signed [GAIN_BITS-1:0]   g_l_reg;
    logic signed [GAIN_BITS-1:0]   g_r_reg;
    logic signed [PROD_BITS-1:0]   v_l_reg;
    logic signed [PROD_BITS-1:0]   v_r_reg;

    logic [SINE_INDEX_BITS-1:0]    addr_l;
    logic [SINE_INDEX_BITS-1:0]    addr_r;
    logic signed [DEPTH_BITS:0]    d_s;
    logic [DEPTH_BITS-1:0]         d_inv;
    logic signed [GAIN_BITS-1:0]   base;
    logic signed [GAIN_BITS-1:0]   ds_l;
    logic signed [GAIN_BITS-1:0]   ds_r;
    logic signed [GAIN_BITS-1:0]   gsum_l;
    logic signed [GAIN_BITS-1:0]   gsum_r;
    logic signed [PROD_BITS-1:0]   v_l_next;
    logic signed [PROD_BITS-1:0]   v_r_next;

    // constant ROM, filled at elaboration
    for (genvar i = 0; i < TABLE_SIZE; i++)
    begin : g_rom
        assign sine_rom[i] = sine_entry(i, SINE_INDEX_BITS);
    end

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PROD_BITS-1:0] v);
        logic signed [Y_BITS-1:0] y;
        y = v[PROD_BITS-1:30];  // floor(v / 2^30)
        if (y > Y_MAX)
            y = Y_MAX;
        else if (y < Y_MIN)
            y = Y_MIN;
        return y[SAMPLE_BITS-1:0];
    endfunction

    assign addr_l = mid_head.phase_l[PHASE_BITS-1 -: SINE_INDEX_BITS];
    assign addr_r = mid_head.phase_r[PHASE_BITS-1 -: SINE_INDEX_BITS];

    assign mid_pop  = (state_reg == S_IDLE) && !mid_empty;
    assign out_push = (state_reg == S_PUT) && !out_full;

    // gain = (1 - d) + d * sin, Q30; magnitude stays within 2^30
    assign d_s    = $signed({1'b0, depth});
    assign d_inv  = DEPTH_FULL - depth;
    assign base   = $signed({1'b0, d_inv, 15'b0});
    assign ds_l   = GAIN_BITS'(d_s) * GAIN_BITS'(sin_l_reg);
    assign ds_r   = GAIN_BITS'(d_s) * GAIN_BITS'(sin_r_reg);
    assign gsum_l = base + ds_l;
    assign gsum_r = base + ds_r;

    assign v_l_next = PROD_BITS'(x_l_reg) * PROD_BITS'(g_l_reg) + ROUND_HALF;
    assign v_r_next = PROD_BITS'(x_r_reg) * PROD_BITS'(g_r_reg) + ROUND_HALF;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (!mid_empty) state_next = S_GAIN;
            S_GAIN:  state_next = S_MUL;
            S_MUL:   state_next = S_PUT;
            S_PUT:   if (!out_full) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            sin_l_reg <= sine_rom[addr_l];
            sin_r_reg <= sine_rom[addr_r];
            x_l_reg   <= mid_head.sample.left_in;
            x_r_reg   <= mid_head.sample.right_in;
            last_reg  <= mid_head.sample.block_end;
        end
        if (state_reg == S_GAIN)
        begin
            g_l_reg <= gsum_l;
            g_r_reg <= gsum_r;
        end
        if (state_reg == S_MUL)
        begin
            v_l_reg <= v_l_next;
            v_r_reg <= v_r_next;
        end
    end

    assign out_item.left_out   = sat(v_l_reg);
    assign out_item.right_out  = sat(v_r_reg);
    assign out_item.block_last = last_reg;

endmodule

`default_nettype wire

/* rtl/core/stereo_tremolo_lfo.sv */
// Stereo tremolo with sine LFO. An accepted item passes the mid queue, the back end's
// sine, gain and product registers and the result queue before empty goes low. The back
// end runs its lookup / gain / multiply / write-out sequence on one item at a time.
// Up to 2 items queue at the front and 2 results at the output.
// Reset (rst_n low, async) clears the LFO phase, both queues and the sequencer, and
// loads phase_step = 581610, phase_offset = half cycle, depth = 0. The ROM needs no reset.
`default_nettype none

module stereo_tremolo_lfo #(
    parameter int SINE_INDEX_BITS = 10
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // item intake
    input  wire                              push,
    output logic                             full,
    input  wire  stl_pkg::in_t               sample,
    // results
    output logic                             empty,
    input  wire                              pop,
    output stl_pkg::out_t                    result,
    // config writes, only while idle
    input  wire                              cfg_we,
    input  wire  [stl_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire  [stl_pkg::CFG_BITS-1:0]     cfg_data
);
    import stl_pkg::*;

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    // front -> mid queue
    logic                  mid_push;
    logic                  mid_full;
    mid_t                  mid_in;
    // mid queue -> back
    logic                  mid_pop;
    logic                  mid_empty;
    mid_t                  mid_head;
    // back -> result queue
    logic                  out_push;
    logic                  out_full;
    out_t                  out_item;
    logic [DEPTH_BITS-1:0] depth;

    // Front: takes items, stamps each with the left/right LFO phase and
    // advances the accumulator. Also holds the config registers.
    stl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mid_full  (mid_full),
        .mid_push  (mid_push),
        .mid_item  (mid_in),
        .depth     (depth)
    );

    // Decouples intake from the multi-cycle back end.
    stl_fifo #(
        .item_t (mid_t),
        .DEPTH  (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_item (mid_in),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_item (mid_head),
        .empty   (mid_empty)
    );

    // Back: ROM lookup, gain, scale, round and saturate; one item at a time.
    stl_back #(
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_head  (mid_head),
        .mid_pop   (mid_pop),
        .depth     (depth),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    // Result queue: the back end keeps working while the consumer stalls, until the queue fills.
    stl_fifo #(
        .item_t (out_t),
        .DEPTH  (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_item (out_item),
        .full    (out_full),
        .rd_en   (pop),
        .rd_item (result),
        .empty   (empty)
    );

endmodule

`default_nettype wire

/* rtl/core/stl_checker.sv */
// Port-level checker for stereo_tremolo_lfo, bound to the top level.
// Depends on stl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module stl_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                push,
    input wire                full,
    input wire                empty,
    input wire                pop,
    input wire stl_pkg::out_t result,
    input wire                cfg_we
);
    import stl_pkg::*;

    // mid queue + back end + result queue
    localparam int MAX_INFLIGHT = 5;
    localparam int CNT_BITS = $clog2(MAX_INFLIGHT + 1);
    localparam logic [CNT_BITS-1:0] MAX_CNT  = CNT_BITS'(MAX_INFLIGHT);
    localparam logic [CNT_BITS-1:0] MIN_FULL = CNT_BITS'(2);

    logic [CNT_BITS-1:0] inflight_reg;
    logic                in_acc;
    logic                out_acc;
    logic                out_wait;
    logic                idle;

    assign in_acc   = push && !full;
    assign out_acc  = pop && !empty;
    assign out_wait = !empty && !pop;
    assign idle     = (inflight_reg == '0) && !in_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else if (in_acc && !out_acc)
            inflight_reg <= inflight_reg + CNT_BITS'(1);
        else if (out_acc && !in_acc)
            inflight_reg <= inflight_reg - CNT_BITS'(1);
    end

    `ASSERT_IMPLY(a_result_has_item, clk, rst_n, !empty, inflight_reg != '0, "result w/o item")
    `ASSERT_ALWAYS(a_inflight_bound, clk, rst_n, inflight_reg <= MAX_CNT, "too many in flight")
    `ASSERT_IMPLY(a_full_backlog, clk, rst_n, full, inflight_reg >= MIN_FULL, "full too early")
    `ASSERT_NEXT(a_result_holds, clk, rst_n, out_wait, !empty && $stable(result), "result moved")
    `ASSERT_IMPLY(a_cfg_idle, clk, rst_n, cfg_we, idle, "cfg while busy")

endmodule

bind stereo_tremolo_lfo stl_checker u_stl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result),
    .cfg_we (cfg_we)
);

`default_nettype wire

/* sim/stereo_tremolo_lfo_checker.sv */
// Scoreboard for the stereo tremolo: mirrors the registers and the LFO phase,
// predicts every output item and compares it with what the block hands out.
// Depends on stl_pkg for the item types, widths and register indexes.
module stereo_tremolo_lfo_checker #(
    parameter int SINE_INDEX_BITS = 10
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              push,
    input  wire                              full,
    input  stl_pkg::in_t                     sample,
    input  wire                              empty,
    input  wire                              pop,
    input  stl_pkg::out_t                    result,
    input  wire                              cfg_we,
    input  wire  [stl_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire  [stl_pkg::CFG_BITS-1:0]     cfg_data,
    output int                               errors,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import stl_pkg::*;

    localparam int ROM_SIZE = 1 << SINE_INDEX_BITS;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;  // pi/2 in Q30
    localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint SAT_LO = -SAT_HI - 64'sd1;

    int                    sine_rom [ROM_SIZE];
    logic [PHASE_BITS-1:0] lfo_phase;
    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] offset_reg;
    logic [DEPTH_BITS-1:0] depth_reg;
    out_t                  modulated_q [$];

    // Quarter-wave sine, Taylor series to x^11 in Horner form, Q30 -> Q1.15.
    function automatic int lfo_sine_q15(input int unsigned idx);
        longint unsigned quarter;
        longint unsigned r;
        longint unsigned x;
        longint unsigned xsq;
        longint unsigned acc;
        longint unsigned mag;
        int unsigned     quad;
        quarter = 64'd1 << (SINE_INDEX_BITS - 2);
        quad    = (idx >> (SINE_INDEX_BITS - 2)) & 3;
        r       = idx & (quarter - 64'd1);
        if (quad % 2 == 1)
            r = quarter - r;
        x   = ((r << (32 - SINE_INDEX_BITS)) * QUARTER_TURN_Q30) >> 30;
        xsq = (x * x) >> 30;
        acc = ONE_Q30;
        // divisors (2n)(2n+1): 110, 72, 42, 20, 6
        for (int n = 5; n >= 1; n--)
            acc = ONE_Q30 - ((xsq * acc) >> 30) / longint'(2 * n * (2 * n + 1));
        mag = (((x * acc) >> 30) + 64'd16384) >> 15;
        if (mag > 64'd32767)
            mag = 64'd32767;
        return (quad >= 2) ? -int'(mag) : int'(mag);
    endfunction

    // gain = (1 - d) + d * sin in Q30, product rounded half up, then saturated
    function automatic logic signed [SAMPLE_BITS-1:0] scale_by_lfo(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic [PHASE_BITS-1:0]         ph,
        input int                            d
    );
        longint g;
        longint y;
        g = longint'(32768 - d) * 64'sd32768
            + longint'(d) * longint'(sine_rom[ph >> (32 - SINE_INDEX_BITS)]);
        y = (longint'(x) * g + 64'sd536870912) >>> 30;
        if (y > SAT_HI)
            y = SAT_HI;
        else if (y < SAT_LO)
            y = SAT_LO;
        return y[SAMPLE_BITS-1:0];
    endfunction

    initial
    begin
        for (int i = 0; i < ROM_SIZE; i++)
            sine_rom[i] = lfo_sine_q15(i);
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        out_t got;
        int   d;
        if (!rst_n)
        begin
            lfo_phase  = '0;
            step_reg   = PHASE_STEP_RESET;
            offset_reg = PHASE_OFFSET_RESET;
            depth_reg  = '0;
            modulated_q.delete();
            pending = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got = result;
                if (modulated_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, expected none, got l=%0d r=%0d last=%0b",
                             $time, got.left_out, got.right_out, got.block_last);
                end
                else
                begin
                    want = modulated_q.pop_front();
                    if (got.left_out !== want.left_out)
                    begin
                        errors++;
                        $display("%0t: left_out expected %0d got %0d",
                                 $time, want.left_out, got.left_out);
                    end
                    if (got.right_out !== want.right_out)
                    begin
                        errors++;
                        $display("%0t: right_out expected %0d got %0d",
                                 $time, want.right_out, got.right_out);
                    end
                    if (got.block_last !== want.block_last)
                    begin
                        errors++;
                        $display("%0t: block_last expected %0b got %0b",
                                 $time, want.block_last, got.block_last);
                    end
                end
            end

            // an item taken at this edge still sees the old register values
            if (push && !full)
            begin
                d = (depth_reg > DEPTH_FULL) ? int'(DEPTH_FULL) : int'(depth_reg);
                want.left_out   = scale_by_lfo(sample.left_in, lfo_phase, d);
                want.right_out  = scale_by_lfo(sample.right_in, lfo_phase + offset_reg, d);
                want.block_last = sample.block_end;
                modulated_q.push_back(want);
                lfo_phase = lfo_phase + step_reg;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PHASE_STEP:   step_reg   = cfg_data;
                    REG_PHASE_OFFSET: offset_reg = cfg_data;
                    REG_DEPTH:        depth_reg  = cfg_data[DEPTH_BITS-1:0];
                    default:          ;  // unknown index: dropped
                endcase
            end
            pending = modulated_q.size();
        end
    end

endmodule

/* sim/tb_stereo_tremolo_lfo.sv */
// Testbench top for stereo_tremolo_lfo: clock, reset, register writes and
// sample-pair stimulus with random idling on both sides; verdict at the end.
// Depends on stl_pkg, the block and stereo_tremolo_lfo_checker.
module tb_stereo_tremolo_lfo;
    timeunit 1ns;
    timeprecision 1ps;
    import stl_pkg::*;

    // index past the last register; writes to it must be dropped
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 65;

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    in_t                     sample;
    logic                    empty;
    logic                    pop;
    out_t                    result;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    // steady: neither side idles; stall_req: ask the pop side for a long hold-off
    logic steady;
    logic stall_req;
    int   errors;
    int   pending;

    stereo_tremolo_lfo #(
        .SINE_INDEX_BITS(10)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stereo_tremolo_lfo_checker #(
        .SINE_INDEX_BITS(10)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Hard stop.
    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Output side. Pops at random ~70% of cycles, always in steady phases,
    // and on the first stall request holds off popping so the block backs up
    // and raises full while the sender keeps offering items.
    initial
    begin
        int   stall_left;
        logic stall_done;
        pop        = 1'b0;
        stall_left = 0;
        stall_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (stall_req && !stall_done)
            begin
                stall_done = 1'b1;
                pop        <= 1'b0;
                stall_left = 79;
            end
            else if (!steady && $urandom_range(99) < 30)
                pop <= 1'b0;
            else
                pop <= 1'b1;
        end
    end

    // One register write per cycle; the caller drops cfg_we after the group.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Offer one sample pair and return at the edge that takes it. push stays
    // high into the next item unless a random gap is taken.
    task automatic send_pair(
        input logic signed [SAMPLE_BITS-1:0] l,
        input logic signed [SAMPLE_BITS-1:0] r,
        input logic                          last
    );
        if (!steady && $urandom_range(99) < 30)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push   <= 1'b1;
        sample <= '{left_in: l, right_in: r, block_end: last};
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted item has been popped.
    // The first edge lets the checker book an item taken at this edge.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly full-range random, with the rails, zero and minus one mixed in.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [PHASE_BITS-1:0] step_val;
        logic [DEPTH_BITS-1:0] depth_val;
        rst_n     = 1'b0;
        push      = 1'b0;
        sample    = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_PHASE_STEP;
        cfg_data  = '0;
        steady    = 1'b0;
        stall_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: depth 0, so gain is exactly one and samples pass through.
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7fff, 1'b0);
        send_pair(16'sh0000, 16'sh0000, 1'b0);
        send_pair(16'shffff, 16'sh0001, 1'b1);
        send_pair(16'sh0001, 16'shffff, 1'b0);

        // Full depth, quarter-turn step and no offset: the LFO lands on
        // 0, +1, 0, -1 in turn. A write to the spare index must not stick.
        drain();
        write_reg(REG_DEPTH, CFG_BITS'(DEPTH_FULL));
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_PHASE_OFFSET, 32'h0000_0000);
        write_reg(REG_UNUSED, 32'hffff_ffff);
        cfg_we <= 1'b0;
        send_pair(16'sh7fff, 16'sh8000, 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff, 1'b0);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sh4000, 16'shc000, 1'b0);
        send_pair(16'sh0001, 16'shffff, 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 1'b1);

        // Depth register above full acts as full; maximum step and offset
        // make the phase wrap on every item.
        drain();
        write_reg(REG_DEPTH, 32'h0000_ffff);
        write_reg(REG_PHASE_STEP, 32'hffff_ffff);
        write_reg(REG_PHASE_OFFSET, 32'hffff_ffff);
        cfg_we <= 1'b0;
        send_pair(16'sh7fff, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sh1234, 16'shedcb, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sh0000, 16'shffff, 1'b1);

        // Random phases, each with fresh settings written while idle.
        // Phase 2 runs without idling on either side; phase 4 starts with a
        // long output stall so the input backs up.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            case ($urandom_range(0, 3))
                0:       step_val = $urandom_range(1, 1 << 22);
                1:       step_val = $urandom;
                2:       step_val = '0;
                default: step_val = 32'hffff_ffff - $urandom_range(0, 1 << 22);
            endcase
            case ($urandom_range(0, 4))
                0:       depth_val = '0;
                1:       depth_val = DEPTH_FULL;
                2:       depth_val = DEPTH_BITS'($urandom_range(32769, 65535));
                default: depth_val = DEPTH_BITS'($urandom_range(0, 32768));
            endcase
            write_reg(REG_PHASE_STEP, step_val);
            write_reg(REG_PHASE_OFFSET, $urandom);
            write_reg(REG_DEPTH, CFG_BITS'(depth_val));
            cfg_we <= 1'b0;
            steady <= (ph == 2);
            if (ph == 4)
                stall_req <= 1'b1;
            repeat (ITEMS_PER_PHASE)
                send_pair(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
        end

        // Everything sent: let the last items come out, then a short tail
        // to catch anything extra the block might still produce.
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/stl_pkg.sv
rtl/core/stl_fifo.sv
rtl/core/stl_front.sv
rtl/core/stl_back.sv
rtl/core/stereo_tremolo_lfo.sv
rtl/core/stl_checker.sv
sim/stereo_tremolo_lfo_checker.sv
sim/tb_stereo_tremolo_lfo.sv
